// ===== rtl/core/lpd_pkg.sv =====
// Shared constants for the lidar scan packet deframer.
package lpd_pkg;

	localparam int MAX_SAMPLES = 64;
	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	localparam int BYTE_W = 8;
	localparam int WORD_W = 16;
	localparam int ANGLE_W = 15;

	localparam logic [BYTE_W-1:0] SYNC_BYTE0 = 8'hAA;
	localparam logic [BYTE_W-1:0] SYNC_BYTE1 = 8'h55;

endpackage

// ===== rtl/core/lpd_byte_if.sv =====
// Serial byte channel: valid/ready with one received byte.
interface lpd_byte_if;
	logic                          valid;
	logic                          ready;
	logic [lpd_pkg::BYTE_W-1:0]    rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/lpd_sample_if.sv =====
// Sample channel: valid/ready with one decoded distance sample and packet info.
interface lpd_sample_if;
	logic                          valid;
	logic                          ready;
	logic [lpd_pkg::WORD_W-1:0]    distance_raw;
	logic [lpd_pkg::ANGLE_W-1:0]   start_angle_raw;
	logic [lpd_pkg::ANGLE_W-1:0]   end_angle_raw;
	logic [lpd_pkg::IDX_W-1:0]     sample_index;
	logic [lpd_pkg::CNT_W-1:0]     sample_total;
	logic                          zero_packet;
	logic [lpd_pkg::WORD_W-1:0]    check_code;
	logic                          last;

	modport source (output valid, output distance_raw, output start_angle_raw,
		output end_angle_raw, output sample_index, output sample_total,
		output zero_packet, output check_code, output last, input ready);
	modport sink (input valid, input distance_raw, input start_angle_raw,
		input end_angle_raw, input sample_index, input sample_total,
		input zero_packet, input check_code, input last, output ready);
endinterface

// ===== rtl/core/lpd_sample_ram.sv =====
// Sample buffer: one write port, one read port with registered read data.
module lpd_sample_ram (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [lpd_pkg::IDX_W-1:0]   wr_addr,
	input  logic [lpd_pkg::WORD_W-1:0]  wr_data,
	input  logic                        rd_en,
	input  logic [lpd_pkg::IDX_W-1:0]   rd_addr,
	output logic [lpd_pkg::WORD_W-1:0]  rd_data
);

	logic [lpd_pkg::WORD_W-1:0] mem [lpd_pkg::MAX_SAMPLES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/lidar_packet_deframer.sv =====
// Scan packet deframer: byte parser, sample buffer and sample read-out.
//
// Usage:
//   rx  : one serial byte per item. Packets are 0xAA 0x55, type, count,
//         start angle, end angle, check code (16-bit LE each), then 16-bit
//         LE distance samples, which are written to the sample buffer.
//   smp : one item per buffered sample, with the packet's angles, check
//         code, zero-packet flag, index, total and a last marker.
//   While parsing, rx takes one byte per cycle. The byte that closes a
//   packet (0xAA after the declared count) starts a read-out of N samples
//   (N up to 64). For each sample the control goes through M_READ, where
//   the single buffer read port reads it, and then M_SHOW, where the
//   registered data is offered; the next sample is read only after the
//   current one is accepted.
//   rx.ready stays low during the read-out; a stall on smp holds the item
//   in place and extends the run. The buffer needs no clearing.
//   Reset (arst_n low) returns the parser to waiting for 0xAA and drops
//   any run in progress.
module lidar_packet_deframer (
	input  logic         clk,
	input  logic         arst_n,
	lpd_byte_if.sink     rx,
	lpd_sample_if.source smp
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_HDR1, PH_HDR2, PH_TYPE, PH_COUNT, PH_SA_LO, PH_SA_HI,
		PH_EA_LO, PH_EA_HI, PH_CC_LO, PH_CC_HI, PH_S_LO, PH_S_HI
	} phase_t;

	typedef enum logic [1:0] {M_PARSE, M_READ, M_SHOW} mode_t;

	localparam logic [lpd_pkg::CNT_W-1:0] MAX_CNT = lpd_pkg::CNT_W'(lpd_pkg::MAX_SAMPLES);

	phase_t                         phase_q;
	mode_t                          mode_q;
	logic [lpd_pkg::CNT_W-1:0]      cnt_q;
	logic [lpd_pkg::CNT_W-1:0]      total_q;
	logic [lpd_pkg::IDX_W-1:0]      idx_q;
	logic [lpd_pkg::BYTE_W-1:0]     decl_q;
	logic [lpd_pkg::BYTE_W-1:0]     lo_q;
	logic [lpd_pkg::ANGLE_W-1:0]    sa_q;
	logic [lpd_pkg::ANGLE_W-1:0]    ea_q;
	logic [lpd_pkg::WORD_W-1:0]     chk_q;
	logic                           zero_q;

	logic                           rx_fire;
	logic                           smp_fire;
	logic [lpd_pkg::BYTE_W-1:0]     ch;
	logic [lpd_pkg::WORD_W-1:0]     word;
	logic                           wr_en;
	logic                           rd_en;
	logic                           is_last;
	logic [lpd_pkg::WORD_W-1:0]     rd_data;

	assign ch       = rx.rx_byte;
	assign word     = {ch, lo_q};
	assign rx.ready = (mode_q == M_PARSE);
	assign rx_fire  = rx.valid && rx.ready;
	assign smp_fire = smp.valid && smp.ready;
	assign wr_en    = rx_fire && (phase_q == PH_S_LO) && (cnt_q < MAX_CNT);
	assign rd_en    = (mode_q == M_READ);
	assign is_last  = ({1'b0, idx_q} + lpd_pkg::CNT_W'(1)) == total_q;

	lpd_sample_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[lpd_pkg::IDX_W-1:0]),
		.wr_data (word),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			mode_q  <= M_PARSE;
			cnt_q   <= '0;
			total_q <= '0;
			idx_q   <= '0;
		end else begin
			case (mode_q)
				M_READ: begin
					mode_q <= M_SHOW;
				end
				M_SHOW: begin
					if (smp.ready) begin
						if (is_last) begin
							mode_q <= M_PARSE;
						end else begin
							idx_q  <= idx_q + lpd_pkg::IDX_W'(1);
							mode_q <= M_READ;
						end
					end
				end
				default: begin
					if (rx_fire) begin
						case (phase_q)
							PH_HDR1: begin
								if (ch == lpd_pkg::SYNC_BYTE1) begin
									phase_q <= PH_HDR2;
								end else begin
									phase_q <= PH_IDLE;
									cnt_q   <= '0;
								end
							end
							PH_HDR2:  phase_q <= PH_TYPE;
							PH_TYPE:  phase_q <= PH_COUNT;
							PH_COUNT: phase_q <= PH_SA_LO;
							PH_SA_LO: phase_q <= PH_SA_HI;
							PH_SA_HI: phase_q <= PH_EA_LO;
							PH_EA_LO: phase_q <= PH_EA_HI;
							PH_EA_HI: phase_q <= PH_CC_LO;
							PH_CC_LO: phase_q <= PH_CC_HI;
							PH_CC_HI: begin
								cnt_q   <= '0;
								phase_q <= PH_S_LO;
							end
							PH_S_LO: begin
								if (cnt_q < MAX_CNT) begin
									cnt_q   <= cnt_q + lpd_pkg::CNT_W'(1);
									phase_q <= PH_S_HI;
								end else begin
									phase_q <= PH_IDLE;
									cnt_q   <= '0;
								end
							end
							PH_S_HI: begin
								if ({1'b0, cnt_q} >= decl_q) begin
									if (ch == lpd_pkg::SYNC_BYTE0) begin
										total_q <= cnt_q;
										idx_q   <= '0;
										mode_q  <= M_READ;
										phase_q <= PH_HDR1;
									end else begin
										phase_q <= PH_IDLE;
									end
									cnt_q <= '0;
								end else if (cnt_q >= MAX_CNT) begin
									phase_q <= PH_IDLE;
									cnt_q   <= '0;
								end else begin
									phase_q <= PH_S_LO;
								end
							end
							default: begin
								phase_q <= (ch == lpd_pkg::SYNC_BYTE0) ? PH_HDR1 : PH_IDLE;
								cnt_q   <= '0;
							end
						endcase
					end
				end
			endcase
		end
	end

	// packet fields
	always_ff @(posedge clk) begin
		if (rx_fire) begin
			case (phase_q)
				PH_HDR2:  zero_q <= ch[0];
				PH_TYPE:  decl_q <= ch;
				PH_SA_LO: sa_q   <= word[lpd_pkg::WORD_W-1:1];
				PH_EA_LO: ea_q   <= word[lpd_pkg::WORD_W-1:1];
				PH_CC_LO: chk_q  <= word;
				PH_COUNT, PH_SA_HI, PH_EA_HI, PH_CC_HI, PH_S_HI: lo_q <= ch;
				default: ;
			endcase
		end
	end

	assign smp.valid           = (mode_q == M_SHOW);
	assign smp.distance_raw    = rd_data;
	assign smp.start_angle_raw = sa_q;
	assign smp.end_angle_raw   = ea_q;
	assign smp.sample_index    = idx_q;
	assign smp.sample_total    = total_q;
	assign smp.zero_packet     = zero_q;
	assign smp.check_code      = chk_q;
	assign smp.last            = is_last;

`ifndef SYNTHESIS
	a_no_rx_during_run: assert property (@(posedge clk) disable iff (!arst_n)
		smp.valid |-> !rx.ready)
		else $error("byte taken during sample read-out");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("sample count beyond buffer depth");

	a_index_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		smp.valid |-> ({1'b0, idx_q} < total_q))
		else $error("sample index outside packet total");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_fire && smp.last) |=> (rx.ready && !smp.valid))
		else $error("read-out did not end after last sample");

	a_read_then_show: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_fire && !smp.last) |=> (!smp.valid ##1 smp.valid))
		else $error("next sample not presented after buffer read");
`endif

endmodule
